// ----- hw/rtl/lri_pkg.sv -----
// ----------------------------------------------------------------------------
// lri_pkg
// Shared types and constants of the line rasterizer with color interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

package lri_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_BITS_DEF = 16;
    localparam int SCREEN_BITS    = 11;
    localparam int NUM_LANES      = 5;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic REG_MAX_X = 1'b0;
    localparam logic REG_MAX_Y = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIV
    } lri_state_t;

    typedef struct packed {
        logic valid;
        logic is_load;
    } lri_q_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lri_front.sv -----
// ----------------------------------------------------------------------------
// lri_front
// Accepts requests into a two-entry queue and tags each as load or step.
// ----------------------------------------------------------------------------
`default_nettype none

module lri_front #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         cmd,
    input  wire logic signed [COORD_BITS-1:0] x_a,
    input  wire logic signed [COORD_BITS-1:0] y_a,
    input  wire logic        [DEPTH_BITS-1:0] z_a,
    input  wire logic        [31:0]           color_a,
    input  wire logic signed [COORD_BITS-1:0] x_b,
    input  wire logic signed [COORD_BITS-1:0] y_b,
    input  wire logic        [DEPTH_BITS-1:0] z_b,
    input  wire logic        [31:0]           color_b,
    output lri_pkg::lri_q_stat_t              q_stat,
    input  wire logic                         q_pop,
    output logic signed [COORD_BITS-1:0]      h_xa,
    output logic signed [COORD_BITS-1:0]      h_ya,
    output logic        [DEPTH_BITS-1:0]      h_za,
    output logic        [31:0]                h_ca,
    output logic signed [COORD_BITS-1:0]      h_xb,
    output logic signed [COORD_BITS-1:0]      h_yb,
    output logic        [DEPTH_BITS-1:0]      h_zb,
    output logic        [31:0]                h_cb
);
    import lri_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic                         cmd_reg [QUEUE_DEPTH];
    logic signed [COORD_BITS-1:0] xa_reg  [QUEUE_DEPTH];
    logic signed [COORD_BITS-1:0] ya_reg  [QUEUE_DEPTH];
    logic        [DEPTH_BITS-1:0] za_reg  [QUEUE_DEPTH];
    logic        [31:0]           ca_reg  [QUEUE_DEPTH];
    logic signed [COORD_BITS-1:0] xb_reg  [QUEUE_DEPTH];
    logic signed [COORD_BITS-1:0] yb_reg  [QUEUE_DEPTH];
    logic        [DEPTH_BITS-1:0] zb_reg  [QUEUE_DEPTH];
    logic        [31:0]           cb_reg  [QUEUE_DEPTH];

    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == CNTW'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = q_pop && (cnt_reg != '0);

    always_comb
    begin
        wptr_next = do_push ? PW'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next = do_pop ? PW'(rptr_reg + 1'b1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = CNTW'(cnt_reg + 1'b1);
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = CNTW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_reg[wptr_reg] <= cmd;
            xa_reg[wptr_reg]  <= x_a;
            ya_reg[wptr_reg]  <= y_a;
            za_reg[wptr_reg]  <= z_a;
            ca_reg[wptr_reg]  <= color_a;
            xb_reg[wptr_reg]  <= x_b;
            yb_reg[wptr_reg]  <= y_b;
            zb_reg[wptr_reg]  <= z_b;
            cb_reg[wptr_reg]  <= color_b;
        end
    end

    assign q_stat.valid   = (cnt_reg != '0);
    assign q_stat.is_load = (cmd_reg[rptr_reg] == CMD_LOAD);
    assign h_xa = xa_reg[rptr_reg];
    assign h_ya = ya_reg[rptr_reg];
    assign h_za = za_reg[rptr_reg];
    assign h_ca = ca_reg[rptr_reg];
    assign h_xb = xb_reg[rptr_reg];
    assign h_yb = yb_reg[rptr_reg];
    assign h_zb = zb_reg[rptr_reg];
    assign h_cb = cb_reg[rptr_reg];

endmodule

`default_nettype wire

// ----- hw/rtl/lri_back.sv -----
// ----------------------------------------------------------------------------
// lri_back
// Line setup, slope division and per-pixel Bresenham stepping with
// incremental depth/color interpolation; holds one result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lri_back #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lri_pkg::lri_q_stat_t                q_stat,
    output logic                                     q_pop,
    input  wire logic signed [COORD_BITS-1:0]        h_xa,
    input  wire logic signed [COORD_BITS-1:0]        h_ya,
    input  wire logic        [DEPTH_BITS-1:0]        h_za,
    input  wire logic        [31:0]                  h_ca,
    input  wire logic signed [COORD_BITS-1:0]        h_xb,
    input  wire logic signed [COORD_BITS-1:0]        h_yb,
    input  wire logic        [DEPTH_BITS-1:0]        h_zb,
    input  wire logic        [31:0]                  h_cb,
    input  wire logic        [lri_pkg::SCREEN_BITS-1:0] max_x,
    input  wire logic        [lri_pkg::SCREEN_BITS-1:0] max_y,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [COORD_BITS-1:0]             pix_x,
    output logic signed [COORD_BITS-1:0]             pix_y,
    output logic        [DEPTH_BITS-1:0]             pix_z,
    output logic        [31:0]                       pix_color,
    output logic                                     on_screen,
    output logic                                     last
);
    import lri_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int LW   = COORD_BITS + 1;
    localparam int EW   = COORD_BITS + 3;
    localparam int DW   = DEPTH_BITS;
    localparam int CTW  = $clog2(DW);

    lri_state_t state_reg, state_next;

    logic                 active_reg;
    logic                 steep_reg;
    logic                 mdir_reg;
    logic signed [CW-1:0] cmaj_reg;
    logic signed [CW-1:0] cmin_reg;
    logic signed [EW-1:0] err_reg;
    logic [LW-1:0]        idx_reg;
    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        dmin_reg;
    logic [CTW-1:0]       cnt_reg;

    logic [DW-1:0] base_reg [NUM_LANES];
    logic          sgn_reg  [NUM_LANES];
    logic [DW-1:0] dvd_reg  [NUM_LANES];
    logic [LW-1:0] rem_reg  [NUM_LANES];
    logic [DW-1:0] qacc_reg [NUM_LANES];
    logic [LW-1:0] racc_reg [NUM_LANES];

    logic                 ovalid_reg;
    logic signed [CW-1:0] ox_reg, oy_reg;
    logic [DW-1:0]        oz_reg;
    logic [31:0]          oc_reg;
    logic                 ovis_reg, olast_reg;

    // setup
    logic signed [CW:0]   dx, dy, dmv;
    logic [LW-1:0]        adx, ady, adm, len_s;
    logic                 steep_s, swap_s;
    logic signed [CW-1:0] ma0, mb0, na0, nb0, ma, mb, na, nb;
    logic [DW-1:0]        za_s, zb_s;
    logic [31:0]          ca_s, cb_s;
    logic [DW-1:0]        la [NUM_LANES];
    logic [DW-1:0]        lb [NUM_LANES];

    always_comb
    begin
        dx = {h_xb[CW-1], h_xb} - {h_xa[CW-1], h_xa};
        dy = {h_yb[CW-1], h_yb} - {h_ya[CW-1], h_ya};
        adx = dx[CW] ? LW'(-dx) : LW'(dx);
        ady = dy[CW] ? LW'(-dy) : LW'(dy);
        steep_s = !(ady < adx);
        ma0 = steep_s ? h_ya : h_xa;
        mb0 = steep_s ? h_yb : h_xb;
        na0 = steep_s ? h_xa : h_ya;
        nb0 = steep_s ? h_xb : h_yb;
        swap_s = ma0 > mb0;
        ma = swap_s ? mb0 : ma0;
        mb = swap_s ? ma0 : mb0;
        na = swap_s ? nb0 : na0;
        nb = swap_s ? na0 : nb0;
        za_s = swap_s ? h_zb : h_za;
        zb_s = swap_s ? h_za : h_zb;
        ca_s = swap_s ? h_cb : h_ca;
        cb_s = swap_s ? h_ca : h_cb;
        len_s = LW'({mb[CW-1], mb} - {ma[CW-1], ma});
        dmv = {nb[CW-1], nb} - {na[CW-1], na};
        adm = dmv[CW] ? LW'(-dmv) : LW'(dmv);
        la[0] = za_s;
        lb[0] = zb_s;
        for (int k = 0; k < NUM_LANES - 1; k++)
        begin
            la[k+1] = DW'(ca_s[8*k +: 8]);
            lb[k+1] = DW'(cb_s[8*k +: 8]);
        end
    end

    // pixel value
    logic [DW-1:0]        val [NUM_LANES];
    logic signed [CW-1:0] px, py;
    logic                 vis, is_last, out_free, do_load, do_step;
    logic [31:0]          col;

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            val[k] = sgn_reg[k] ? DW'(base_reg[k] - qacc_reg[k])
                                : DW'(base_reg[k] + qacc_reg[k]);
        end
        for (int k = 0; k < NUM_LANES - 1; k++)
        begin
            col[8*k +: 8] = val[k+1][7:0];
        end
        px = steep_reg ? cmin_reg : cmaj_reg;
        py = steep_reg ? cmaj_reg : cmin_reg;
        vis = !px[CW-1] && !py[CW-1]
              && (32'(unsigned'(px)) <= 32'(max_x))
              && (32'(unsigned'(py)) <= 32'(max_y));
        is_last = (idx_reg >= len_reg);
    end

    assign out_free = !ovalid_reg || pop;

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.valid && q_stat.is_load)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CTW'(DW - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        q_pop   = 1'b0;
        do_load = 1'b0;
        do_step = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.valid)
                begin
                    if (q_stat.is_load)
                    begin
                        q_pop   = 1'b1;
                        do_load = 1'b1;
                    end
                    else if (!active_reg)
                    begin
                        q_pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        q_pop   = 1'b1;
                        do_step = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                q_pop = 1'b0;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_load)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= CTW'(cnt_reg + 1'b1);
            end
            if (do_step && is_last)
            begin
                active_reg <= 1'b0;
            end
            if (do_step)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (pop)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    logic [LW:0]   rtry [NUM_LANES];
    logic [LW:0]   rsum [NUM_LANES];

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            rtry[k] = {rem_reg[k], dvd_reg[k][DW-1]};
            rsum[k] = {1'b0, racc_reg[k]} + {1'b0, rem_reg[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            steep_reg <= steep_s;
            mdir_reg  <= dmv[CW];
            cmaj_reg  <= ma;
            cmin_reg  <= na;
            len_reg   <= len_s;
            dmin_reg  <= adm;
            idx_reg   <= '0;
            err_reg   <= EW'({1'b0, adm, 1'b0}) - EW'({2'b00, len_s});
            for (int k = 0; k < NUM_LANES; k++)
            begin
                base_reg[k] <= la[k];
                sgn_reg[k]  <= lb[k] < la[k];
                dvd_reg[k]  <= (lb[k] < la[k]) ? DW'(la[k] - lb[k]) : DW'(lb[k] - la[k]);
                rem_reg[k]  <= '0;
                qacc_reg[k] <= '0;
                racc_reg[k] <= '0;
            end
        end
        else if (state_reg == ST_DIV)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                if (rtry[k] >= {1'b0, len_reg})
                begin
                    rem_reg[k] <= LW'(rtry[k] - {1'b0, len_reg});
                    dvd_reg[k] <= {dvd_reg[k][DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= LW'(rtry[k]);
                    dvd_reg[k] <= {dvd_reg[k][DW-2:0], 1'b0};
                end
            end
        end
        else if (do_step && !is_last)
        begin
            if (err_reg > 0)
            begin
                cmin_reg <= mdir_reg ? CW'(cmin_reg - 1'b1) : CW'(cmin_reg + 1'b1);
                err_reg  <= EW'(err_reg + EW'({1'b0, dmin_reg, 1'b0})
                                - EW'({1'b0, len_reg, 1'b0}));
            end
            else
            begin
                err_reg <= EW'(err_reg + EW'({1'b0, dmin_reg, 1'b0}));
            end
            cmaj_reg <= CW'(cmaj_reg + 1'b1);
            idx_reg  <= LW'(idx_reg + 1'b1);
            for (int k = 0; k < NUM_LANES; k++)
            begin
                if (rsum[k] >= {1'b0, len_reg})
                begin
                    racc_reg[k] <= LW'(rsum[k] - {1'b0, len_reg});
                    qacc_reg[k] <= DW'(qacc_reg[k] + dvd_reg[k] + 1'b1);
                end
                else
                begin
                    racc_reg[k] <= LW'(rsum[k]);
                    qacc_reg[k] <= DW'(qacc_reg[k] + dvd_reg[k]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            ox_reg    <= px;
            oy_reg    <= py;
            oz_reg    <= val[0];
            oc_reg    <= col;
            ovis_reg  <= vis;
            olast_reg <= is_last;
        end
    end

    assign empty     = !ovalid_reg;
    assign pix_x     = ox_reg;
    assign pix_y     = oy_reg;
    assign pix_z     = oz_reg;
    assign pix_color = oc_reg;
    assign on_screen = ovis_reg;
    assign last      = olast_reg;

    a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !q_pop)
        else $error("queue popped during division");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !pop) |=> ($stable(ox_reg) && $stable(oc_reg)))
        else $error("result overwritten while waiting");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && state_reg == ST_IDLE) |-> (idx_reg <= len_reg))
        else $error("step index past line length");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (do_step && is_last) |=> !active_reg)
        else $error("line still active after last pixel");

endmodule

`default_nettype wire

// ----- hw/rtl/line_rasterizer_color_interp_top.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer_color_interp_top
// Bresenham line rasterizer with interpolated depth and RGBA color.
//
// Requests enter through push/full: cmd 0 loads a line from the two
// endpoints, cmd 1 asks for the next pixel. Pixels leave through empty/pop,
// oldest first; the pixel on the ports is held until popped.
// Requests pass a two-entry queue to the line engine, so the sender is not
// held up by a stalled receiver until the queue fills.
// A load runs a setup step in the engine, then a restoring divider in every
// lane that produces one quotient bit a cycle.
// With the engine free, a step request is taken from the queue and its pixel
// is registered into the result register on the ports, and steps sustain one
// pixel per cycle while the receiver pops. A held pixel stalls further steps
// in the queue.
// Steps with no active line are dropped. max_x/max_y are written over the
// APB port at byte addresses 0 and 4 and reset to 2047.
// Reset empties the queue and the result register and clears the line.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_color_interp_top #(
    parameter int COORD_BITS = lri_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = lri_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         cmd,
    input  wire logic signed [COORD_BITS-1:0] x_a,
    input  wire logic signed [COORD_BITS-1:0] y_a,
    input  wire logic        [DEPTH_BITS-1:0] z_a,
    input  wire logic        [31:0]           color_a,
    input  wire logic signed [COORD_BITS-1:0] x_b,
    input  wire logic signed [COORD_BITS-1:0] y_b,
    input  wire logic        [DEPTH_BITS-1:0] z_b,
    input  wire logic        [31:0]           color_b,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [COORD_BITS-1:0]      pix_x,
    output logic signed [COORD_BITS-1:0]      pix_y,
    output logic        [DEPTH_BITS-1:0]      pix_z,
    output logic        [31:0]                pix_color,
    output logic                              on_screen,
    output logic                              last
);
    import lri_pkg::*;

    logic [SCREEN_BITS-1:0] max_x_reg, max_y_reg;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= '1;
            max_y_reg <= '1;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MAX_X)
            begin
                max_x_reg <= pwdata[SCREEN_BITS-1:0];
            end
            else
            begin
                max_y_reg <= pwdata[SCREEN_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MAX_X)
        begin
            prdata = 32'(max_x_reg);
        end
        else
        begin
            prdata = 32'(max_y_reg);
        end
    end

    lri_q_stat_t                 q_stat;
    logic                        q_pop;
    logic signed [COORD_BITS-1:0] h_xa, h_ya, h_xb, h_yb;
    logic        [DEPTH_BITS-1:0] h_za, h_zb;
    logic        [31:0]           h_ca, h_cb;

    lri_front #(
        .COORD_BITS(COORD_BITS),
        .DEPTH_BITS(DEPTH_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cmd     (cmd),
        .x_a     (x_a),
        .y_a     (y_a),
        .z_a     (z_a),
        .color_a (color_a),
        .x_b     (x_b),
        .y_b     (y_b),
        .z_b     (z_b),
        .color_b (color_b),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .h_xa    (h_xa),
        .h_ya    (h_ya),
        .h_za    (h_za),
        .h_ca    (h_ca),
        .h_xb    (h_xb),
        .h_yb    (h_yb),
        .h_zb    (h_zb),
        .h_cb    (h_cb)
    );

    lri_back #(
        .COORD_BITS(COORD_BITS),
        .DEPTH_BITS(DEPTH_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .h_xa      (h_xa),
        .h_ya      (h_ya),
        .h_za      (h_za),
        .h_ca      (h_ca),
        .h_xb      (h_xb),
        .h_yb      (h_yb),
        .h_zb      (h_zb),
        .h_cb      (h_cb),
        .max_x     (max_x_reg),
        .max_y     (max_y_reg),
        .empty     (empty),
        .pop       (pop),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .pix_z     (pix_z),
        .pix_color (pix_color),
        .on_screen (on_screen),
        .last      (last)
    );

endmodule

`default_nettype wire
